/* rtl/lpfd_pkg.sv */
// ----------------------------------------------------------------------------
// Length-prefixed frame decoder package
// Shared types and constants for the frame decoder.
// ----------------------------------------------------------------------------
package lpfd_pkg;

   localparam int unsigned MaxPayloadBytes   = 8;
   localparam int unsigned LenFieldBytes     = 4;
   localparam int unsigned IdPayloadBytes    = 8;
   localparam int unsigned InputPayloadBytes = 5;

   localparam int unsigned CountWidth = 4;
   localparam int unsigned WordWidth  = 64;

   typedef enum logic [1:0] {
      PH_LENGTH  = 2'd0,
      PH_TYPE    = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_ERROR   = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      CLS_JOIN      = 3'd0,
      CLS_RECONNECT = 3'd1,
      CLS_INPUT     = 3'd2,
      CLS_LEAVE     = 3'd3,
      CLS_OTHER     = 3'd4
   } class_type;

   typedef enum logic [2:0] {
      REG_JOIN_CODE      = 3'd0,
      REG_RECONNECT_CODE = 3'd1,
      REG_INPUT_CODE     = 3'd2,
      REG_LEAVE_CODE     = 3'd3,
      REG_FLAG_MASK      = 3'd4
   } reg_index_type;

   localparam logic FRAME_OK        = 1'b0;
   localparam logic FRAME_BAD_LEN   = 1'b1;

   typedef struct packed {
      logic [7:0]            move_flags;
      logic signed [15:0]    move_y;
      logic signed [15:0]    move_x;
      logic [WordWidth-1:0]  identifier;
      logic [WordWidth-1:0]  payload_word;
      logic [CountWidth-1:0] payload_count;
      logic [7:0]            type_byte;
   } result_type;

endpackage

/* rtl/length_prefixed_frame_decoder.sv */
// ----------------------------------------------------------------------------
// Length-prefixed frame decoder
// Decodes a byte stream of 4-byte big-endian length, type byte and payload
// into one classified result per frame.
// ----------------------------------------------------------------------------
// Takes one byte per cycle on req_ and gives at most one result per byte on
// rsp_; the result of a byte is registered in the output register when the byte
// is accepted. The input is stalled only while the output register holds a
// result that rsp_tready does not take. A length field outside 1 to 9 gives
// one result with the error status, after which every byte is taken and
// dropped until reset. Register writes land on the next clock edge.
module length_prefixed_frame_decoder (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,    // [7:0] data_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [183:0] rsp_tdata,    // [7:0] type_byte, [11:8] payload_count,
                                      // [75:12] payload_word, [139:76] identifier,
                                      // [155:140] move_x, [171:156] move_y,
                                      // [179:172] move_flags, [183:180] zero
   output logic [3:0]   rsp_tuser,    // [0] frame_status, [3:1] message_class
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [7:0]   csr_wdata
);

   localparam int unsigned CW = lpfd_pkg::CountWidth;
   localparam int unsigned WW = lpfd_pkg::WordWidth;

   logic [7:0] join_code_ff, reconnect_code_ff, input_code_ff, leave_code_ff;
   logic [7:0] flag_mask_ff;

   lpfd_pkg::phase_type phase_ff, phase_in;
   logic [31:0]   length_shift_ff, length_shift_in;
   logic [CW-1:0] byte_counter_ff, byte_counter_in;
   logic [CW-1:0] frame_length_ff, frame_length_in;
   logic [7:0]    held_type_ff, held_type_in;
   logic [WW-1:0] payload_acc_ff, payload_acc_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_status_ff, rsp_status_in;
   lpfd_pkg::class_type   rsp_class_ff, rsp_class_in;
   lpfd_pkg::result_type  rsp_result_ff, rsp_result_in;

   logic          accept;
   logic          emit;
   logic          emit_frame;
   logic [31:0]   shift_next;
   logic [CW-1:0] count_next;
   logic [WW-1:0] acc_next;
   logic [7:0]    frame_type;
   logic [7:0]    flags_byte;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         join_code_ff      <= 8'd1;
         reconnect_code_ff <= 8'd2;
         input_code_ff     <= 8'd3;
         leave_code_ff     <= 8'd4;
         flag_mask_ff      <= 8'd1;
      end else if (csr_we) begin
         case (csr_addr)
            lpfd_pkg::REG_JOIN_CODE:      join_code_ff      <= csr_wdata;
            lpfd_pkg::REG_RECONNECT_CODE: reconnect_code_ff <= csr_wdata;
            lpfd_pkg::REG_INPUT_CODE:     input_code_ff     <= csr_wdata;
            lpfd_pkg::REG_LEAVE_CODE:     leave_code_ff     <= csr_wdata;
            lpfd_pkg::REG_FLAG_MASK:      flag_mask_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      shift_next = {length_shift_ff[23:0], req_tdata};
      count_next = byte_counter_ff + CW'(1);
      acc_next   = {payload_acc_ff[WW-9:0], req_tdata};

      phase_in        = phase_ff;
      length_shift_in = length_shift_ff;
      byte_counter_in = byte_counter_ff;
      frame_length_in = frame_length_ff;
      held_type_in    = held_type_ff;
      payload_acc_in  = payload_acc_ff;
      emit            = 1'b0;
      emit_frame      = 1'b0;
      frame_type      = held_type_ff;

      case (phase_ff)
         lpfd_pkg::PH_LENGTH: begin
            length_shift_in = shift_next;
            byte_counter_in = count_next;
            if (count_next >= CW'(lpfd_pkg::LenFieldBytes)) begin
               byte_counter_in = '0;
               if (shift_next == 32'd0 ||
                   shift_next > 32'(1 + lpfd_pkg::MaxPayloadBytes)) begin
                  phase_in = lpfd_pkg::PH_ERROR;
                  emit     = 1'b1;
               end else begin
                  frame_length_in = CW'(shift_next - 32'd1);
                  payload_acc_in  = '0;
                  phase_in        = lpfd_pkg::PH_TYPE;
               end
            end
         end
         lpfd_pkg::PH_TYPE: begin
            held_type_in    = req_tdata;
            frame_type      = req_tdata;
            byte_counter_in = '0;
            if (frame_length_ff == '0) begin
               emit       = 1'b1;
               emit_frame = 1'b1;
            end else begin
               phase_in = lpfd_pkg::PH_PAYLOAD;
            end
         end
         lpfd_pkg::PH_PAYLOAD: begin
            payload_acc_in  = acc_next;
            byte_counter_in = count_next;
            if (count_next >= frame_length_ff) begin
               emit       = 1'b1;
               emit_frame = 1'b1;
            end
         end
         default: ;
      endcase

      if (emit_frame) begin
         phase_in        = lpfd_pkg::PH_LENGTH;
         length_shift_in = '0;
         byte_counter_in = '0;
         frame_length_in = '0;
         payload_acc_in  = '0;
      end
   end

   always_comb begin
      logic [WW-1:0] w;
      w          = (phase_ff == lpfd_pkg::PH_PAYLOAD) ? acc_next : payload_acc_ff;
      flags_byte = w[7:0];

      rsp_status_in = lpfd_pkg::FRAME_OK;
      rsp_class_in  = lpfd_pkg::CLS_OTHER;
      rsp_result_in = '0;

      if (!emit_frame) begin
         rsp_status_in = lpfd_pkg::FRAME_BAD_LEN;
      end else begin
         rsp_result_in.type_byte     = frame_type;
         rsp_result_in.payload_count = frame_length_ff;
         rsp_result_in.payload_word  = w;
         if (frame_type == join_code_ff &&
             frame_length_ff == CW'(lpfd_pkg::IdPayloadBytes)) begin
            rsp_class_in             = lpfd_pkg::CLS_JOIN;
            rsp_result_in.identifier = w;
         end else if (frame_type == reconnect_code_ff &&
                      frame_length_ff == CW'(lpfd_pkg::IdPayloadBytes)) begin
            rsp_class_in             = lpfd_pkg::CLS_RECONNECT;
            rsp_result_in.identifier = w;
         end else if (frame_type == input_code_ff &&
                      frame_length_ff == CW'(lpfd_pkg::InputPayloadBytes) &&
                      (flags_byte & ~flag_mask_ff) == 8'd0) begin
            rsp_class_in             = lpfd_pkg::CLS_INPUT;
            rsp_result_in.move_x     = w[39:24];
            rsp_result_in.move_y     = w[23:8];
            rsp_result_in.move_flags = flags_byte;
         end else if (frame_type == leave_code_ff && frame_length_ff == '0) begin
            rsp_class_in = lpfd_pkg::CLS_LEAVE;
         end
      end
   end

   assign rsp_valid_in = (accept && emit) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= lpfd_pkg::PH_LENGTH;
         length_shift_ff <= '0;
         byte_counter_ff <= '0;
         frame_length_ff <= '0;
         held_type_ff    <= '0;
         payload_acc_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff        <= phase_in;
            length_shift_ff <= length_shift_in;
            byte_counter_ff <= byte_counter_in;
            frame_length_ff <= frame_length_in;
            held_type_ff    <= held_type_in;
            payload_acc_ff  <= payload_acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_class_ff  <= rsp_class_in;
         rsp_result_ff <= rsp_result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_result_ff};
   assign rsp_tuser  = {rsp_class_ff, rsp_status_ff};

endmodule
